// ===== sv/mffd_pkg.sv =====
// ----------------------------------------------------------------------------
// mffd_pkg: shared types and constants for the motor feedback frame decoder
// Stage load strobes, register indexes and Q16.16 angle constants.
// ----------------------------------------------------------------------------
package mffd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MAX      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_MAX      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TORQUE_MAX        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ANGLE_LIMIT = 3'd3;

  localparam int POS_MAX_W = 20;
  localparam int VT_MAX_W  = 24;
  localparam int LIMIT_W   = 47;
  localparam int POS_W     = 21;
  localparam int WPOS_W    = 19;
  localparam int VT_W      = 25;
  localparam int TOTAL_W   = 48;

  // pi and 2*pi in Q16.16, rounded to nearest
  localparam logic signed [21:0] PI_Q     = 22'sd205887;
  localparam logic signed [21:0] TWO_PI_Q = 22'sd411775;

  // one load strobe per pipeline stage after the input register
  typedef struct packed {
    logic prod;
    logic fold;
    logic scale;
    logic cand;
    logic sel;
    logic acc;
  } mffd_ld_t;

endpackage

// ===== sv/mffd_scale.sv =====
// ----------------------------------------------------------------------------
// mffd_scale: linear scaling of raw position, velocity and torque
// Three stages: raw * max, first fold of the divide by 2^k-1, final fold
// with offset by -max.
// ----------------------------------------------------------------------------
module mffd_scale
  import mffd_pkg::*;
(
  input  logic                        clk,
  input  mffd_ld_t                    ld,
  input  logic [15:0]                 pos_raw,
  input  logic [11:0]                 vel_raw,
  input  logic [11:0]                 tor_raw,
  input  logic [POS_MAX_W-1:0]        pos_max,
  input  logic [VT_MAX_W-1:0]         vel_max,
  input  logic [VT_MAX_W-1:0]         tor_max,
  output logic signed [POS_W-1:0]     position,
  output logic signed [VT_W-1:0]      velocity,
  output logic signed [VT_W-1:0]      torque
);

  localparam logic [16:0] D16 = 17'd65535;
  localparam logic [12:0] D12 = 13'd4095;

  // floor(y / 65535) for y below 2^22
  function automatic logic [6:0] corr16(input logic [21:0] y);
    logic [5:0]  a2;
    logic [16:0] y2;
    logic        c;
    a2 = y[21:16];
    y2 = 17'(y[15:0]) + 17'(a2);
    c  = (y2 >= D16);
    return 7'(a2) + 7'(c);
  endfunction

  // floor(y / 4095) for y below 2^26
  function automatic logic [14:0] corr12(input logic [25:0] y);
    logic [13:0] a2;
    logic [14:0] y2;
    logic [2:0]  a3;
    logic [12:0] y3;
    logic        c;
    a2 = y[25:12];
    y2 = 15'(y[11:0]) + 15'(a2);
    a3 = y2[14:12];
    y3 = 13'(y2[11:0]) + 13'(a3);
    c  = (y3 >= D12);
    return 15'(a2) + 15'(a3) + 15'(c);
  endfunction

  logic [35:0] pos_p, vel_p, tor_p;
  logic [35:0] pos_p_next, vel_p_next, tor_p_next;

  logic signed [21:0] pos_am;
  logic signed [25:0] vel_am, tor_am;
  logic [21:0]        pos_y;
  logic [25:0]        vel_y, tor_y;

  logic signed [21:0] pos_next;
  logic signed [25:0] vel_next, tor_next;

  assign pos_p_next = 36'(pos_raw) * 36'(pos_max);
  assign vel_p_next = 36'(vel_raw) * 36'(vel_max);
  assign tor_p_next = 36'(tor_raw) * 36'(tor_max);

  assign pos_next = pos_am + $signed({15'b0, corr16(pos_y)});
  assign vel_next = vel_am + $signed({11'b0, corr12(vel_y)});
  assign tor_next = tor_am + $signed({11'b0, corr12(tor_y)});

  always_ff @(posedge clk) begin
    if (ld.prod) begin
      pos_p <= pos_p_next;
      vel_p <= vel_p_next;
      tor_p <= tor_p_next;
    end
    // x = 2 * p; x = a * 2^k + b, so x / (2^k-1) = a + (a + b) / (2^k-1)
    if (ld.fold) begin
      pos_am <= $signed({1'b0, pos_p[35:15]}) - $signed({2'b0, pos_max});
      pos_y  <= 22'(pos_p[35:15]) + 22'({pos_p[14:0], 1'b0});
      vel_am <= $signed({1'b0, vel_p[35:11]}) - $signed({2'b0, vel_max});
      vel_y  <= 26'(vel_p[35:11]) + 26'({vel_p[10:0], 1'b0});
      tor_am <= $signed({1'b0, tor_p[35:11]}) - $signed({2'b0, tor_max});
      tor_y  <= 26'(tor_p[35:11]) + 26'({tor_p[10:0], 1'b0});
    end
    if (ld.scale) begin
      position <= pos_next[POS_W-1:0];
      velocity <= vel_next[VT_W-1:0];
      torque   <= tor_next[VT_W-1:0];
    end
  end

endmodule

// ===== sv/mffd_unwrap.sv =====
// ----------------------------------------------------------------------------
// mffd_unwrap: position wrap into +-pi and total angle accumulation
// Delta candidates and wrap, shortest delta select, then the running sum
// with the limit reset.
// ----------------------------------------------------------------------------
module mffd_unwrap
  import mffd_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  mffd_ld_t                    ld,
  input  logic signed [POS_W-1:0]     pos_in,
  input  logic [POS_MAX_W-1:0]        pos_max,
  input  logic [LIMIT_W-1:0]          limit,
  output logic signed [POS_W-1:0]     position,
  output logic signed [WPOS_W-1:0]    wrapped_position,
  output logic signed [TOTAL_W-1:0]   unwrapped_angle
);

  function automatic logic [22:0] mag23(input logic signed [22:0] v);
    return v[22] ? 23'(-v) : 23'(v);
  endfunction

  logic signed [POS_W-1:0]   prev;
  logic signed [POS_W-1:0]   pos4, pos5;
  logic signed [WPOS_W-1:0]  wpos4, wpos5;
  logic signed [22:0]        d1, d2, delta;
  logic signed [TOTAL_W-1:0] angle_sum;

  logic signed [22:0] pos_ext, prev_ext, d, span_ext;
  logic signed [22:0] d1_next, d2_next;
  logic signed [21:0] w;
  logic signed [48:0] sum, sum_ext_a, sum_ext_d, lim;
  logic               over;

  always_comb begin
    pos_ext  = 23'(pos_in);
    prev_ext = 23'(prev);
    span_ext = $signed({2'b0, pos_max, 1'b0});
    d        = pos_ext - prev_ext;
    if (d[22]) begin
      d1_next = d + span_ext;
      d2_next = d;
    end else begin
      d1_next = d;
      d2_next = d - span_ext;
    end
    w = 22'(pos_in);
    for (int i = 0; i < 2; i++) begin
      if (w > PI_Q) w = w - TWO_PI_Q;
    end
    for (int i = 0; i < 2; i++) begin
      if (w < -PI_Q) w = w + TWO_PI_Q;
    end
  end

  always_comb begin
    sum_ext_a = 49'(angle_sum);
    sum_ext_d = 49'(delta);
    sum       = sum_ext_a + sum_ext_d;
    lim       = $signed({2'b0, limit});
    over      = (sum > lim) || (sum < -lim);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev      <= '0;
      angle_sum <= '0;
    end else begin
      if (ld.cand) prev <= pos_in;
      if (ld.acc) angle_sum <= over ? '0 : sum[TOTAL_W-1:0];
    end
    if (ld.cand) begin
      pos4  <= pos_in;
      wpos4 <= w[WPOS_W-1:0];
      d1    <= d1_next;
      d2    <= d2_next;
    end
    if (ld.sel) begin
      pos5  <= pos4;
      wpos5 <= wpos4;
      delta <= (mag23(d1) < mag23(d2)) ? d1 : d2;
    end
    if (ld.acc) begin
      position         <= pos5;
      wrapped_position <= wpos5;
    end
  end

  assign unwrapped_angle = angle_sum;

endmodule

// ===== sv/motor_feedback_frame_decode.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_frame_decode: feedback frame unpack, scale and unwrap
// Decodes one 8-byte motor feedback frame per beat into Q16.16 values.
// ----------------------------------------------------------------------------
// Input stream s_*: one 64-bit frame per beat, byte 0 in bits 63..56.
// Output stream m_*: one decoded result per input beat, in order.
// Config port cfg_*: register index and data, written when cfg_we is high;
// write only while the stream is idle. Unknown indexes are ignored.
// Path: frame register, then stages prod, fold, scale, cand, sel, acc.
// Throughput: one frame per cycle while m_tready is high; seven register
// stages, each with its own valid, so a stalled output only backs up into
// empty stages, and s_tready drops only once every stage holds a beat.
// The rate is set by the running total angle: sum, limit compare and
// update are combinational and close back into the total angle register.
// Reset: all stages empty, registers to their reset values, previous
// position and total angle cleared to zero.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decode
  import mffd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [63:0]            s_tdata,   // frame
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // motor_status, position, wrapped_position, velocity, torque,
  // driver_temperature, rotor_temperature, unwrapped angle, zero pad
  output logic [159:0]           m_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef struct packed {
    logic [3:0] status;
    logic [7:0] t_drv;
    logic [7:0] t_rot;
  } meta_t;

  typedef struct packed {
    logic signed [VT_W-1:0] vel;
    logic signed [VT_W-1:0] tor;
  } vt_t;

  logic [POS_MAX_W-1:0] pos_max;
  logic [VT_MAX_W-1:0]  vel_max;
  logic [VT_MAX_W-1:0]  tor_max;
  logic [LIMIT_W-1:0]   limit;

  logic [6:0] v;
  logic [6:0] go;
  logic [6:1] ld;
  mffd_ld_t   ldv;

  logic [63:0] frame;
  meta_t       meta [1:6];
  vt_t         vt   [4:6];

  logic signed [POS_W-1:0]   pos3;
  logic signed [VT_W-1:0]    vel3, tor3;
  logic signed [POS_W-1:0]   pos6;
  logic signed [WPOS_W-1:0]  wpos6;
  logic signed [TOTAL_W-1:0] total6;

  always_comb begin
    go[6] = v[6] & m_tready;
    for (int k = 6; k >= 1; k--) begin
      ld[k]   = v[k-1] & (~v[k] | go[k]);
      go[k-1] = ld[k];
    end
  end

  assign s_tready = ~v[0] | go[0];
  assign ldv = '{prod: ld[1], fold: ld[2], scale: ld[3],
                 cand: ld[4], sel: ld[5], acc: ld[6]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v       <= '0;
      pos_max <= 20'd819200;
      vel_max <= 24'd1966080;
      tor_max <= 24'd655360;
      limit   <= 47'h7FFF_FFFF_FFFF;
    end else begin
      v[0] <= (s_tvalid & s_tready) | (v[0] & ~go[0]);
      for (int k = 1; k <= 6; k++) begin
        v[k] <= ld[k] | (v[k] & ~go[k]);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_POSITION_MAX:      pos_max <= cfg_data[POS_MAX_W-1:0];
          CFG_VELOCITY_MAX:      vel_max <= cfg_data[VT_MAX_W-1:0];
          CFG_TORQUE_MAX:        tor_max <= cfg_data[VT_MAX_W-1:0];
          CFG_TOTAL_ANGLE_LIMIT: limit   <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) frame <= s_tdata;
    if (ld[1]) meta[1] <= '{status: frame[63:60], t_drv: frame[15:8], t_rot: frame[7:0]};
    for (int k = 2; k <= 6; k++) begin
      if (ld[k]) meta[k] <= meta[k-1];
    end
    if (ld[4]) vt[4] <= '{vel: vel3, tor: tor3};
    if (ld[5]) vt[5] <= vt[4];
    if (ld[6]) vt[6] <= vt[5];
  end

  mffd_scale u_scale (
    .clk      (clk),
    .ld       (ldv),
    .pos_raw  (frame[55:40]),
    .vel_raw  (frame[39:28]),
    .tor_raw  (frame[27:16]),
    .pos_max  (pos_max),
    .vel_max  (vel_max),
    .tor_max  (tor_max),
    .position (pos3),
    .velocity (vel3),
    .torque   (tor3)
  );

  mffd_unwrap u_unwrap (
    .clk              (clk),
    .rst              (rst),
    .ld               (ldv),
    .pos_in           (pos3),
    .pos_max          (pos_max),
    .limit            (limit),
    .position         (pos6),
    .wrapped_position (wpos6),
    .unwrapped_angle  (total6)
  );

  assign m_tvalid = v[6];
  assign m_tdata  = {2'b0, total6, meta[6].t_rot, meta[6].t_drv, vt[6].tor, vt[6].vel,
                     wpos6, pos6, meta[6].status};

endmodule
